// ----- src/mzp_pkg.sv -----
package mzp_pkg;

  // move command codes
  localparam logic [3:0] MV_START      = 4'd0;
  localparam logic [3:0] MV_FINISH     = 4'd1;
  localparam logic [3:0] MV_FORWARD    = 4'd2;
  localparam logic [3:0] MV_RIGHT      = 4'd3;
  localparam logic [3:0] MV_LEFT       = 4'd4;
  localparam logic [3:0] MV_BACK       = 4'd5;
  localparam logic [3:0] MV_BACK_RIGHT = 4'd6;
  localparam logic [3:0] MV_BACK_LEFT  = 4'd7;
  localparam logic [3:0] MV_RESET_POSE = 4'd8;

  // headings
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_DIST_FULL    = 3'd0;
  localparam logic [2:0] CFG_DIST_HALF    = 3'd1;
  localparam logic [2:0] CFG_DIST_QUARTER = 3'd2;
  localparam logic [2:0] CFG_SCAN_IN      = 3'd3;
  localparam logic [2:0] CFG_SCAN_EXIT    = 3'd4;

  // curve kinds and speed codes
  localparam logic [1:0] KIND_CONST  = 2'd0;
  localparam logic [1:0] KIND_BRAKE  = 2'd1;
  localparam logic [1:0] KIND_SEARCH = 2'd2;
  localparam logic [7:0] SPEED_NONE  = 8'd255;
  localparam logic [7:0] SPEED_ONE   = 8'd1;

  localparam logic [15:0] CELL_PITCH  = 16'd180;
  localparam logic [15:0] CELL_CENTRE = 16'd90;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef struct packed {
    logic [9:0] dist_full;
    logic [9:0] dist_half;
    logic [9:0] dist_quarter;
    logic [9:0] scan_in;
    logic [9:0] scan_exit;
  } cfg_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
  } point_t;

  // one classified move waiting for the back end
  typedef struct packed {
    logic        fast;
    logic        bad;
    logic [3:0]  code;
    logic [3:0]  run;
    logic [1:0]  heading;
    point_t      centre;
  } entry_t;

  // step a point by mag along a heading, wrapping at 16 bits
  function automatic point_t move_pt(point_t p, logic [1:0] dir, logic [15:0] mag);
    point_t r;
    r = p;
    unique case (dir)
      DIR_UP:    r.y = p.y + mag;
      DIR_RIGHT: r.x = p.x + mag;
      DIR_DOWN:  r.y = p.y - mag;
      DIR_LEFT:  r.x = p.x - mag;
      default:   r = p;
    endcase
    return r;
  endfunction

endpackage

// ----- src/mzp_front.sv -----
module mzp_front
  import mzp_pkg::*;
#(
  parameter int MAX_RUN = 14
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [3:0] in_move_code,
  input  logic [3:0] in_run_length,
  input  logic       q_full,
  output logic       q_push,
  output entry_t     q_entry
);

  logic [1:0] heading_r, heading_nxt;
  logic [7:0] cell_x_r, cell_x_nxt;
  logic [7:0] cell_y_r, cell_y_nxt;
  logic       accept;
  logic       bad;
  logic [3:0] run_eff;
  logic [7:0] adv;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // classify the move against mode and heading
  always_comb begin
    bad = (in_move_code > MV_RESET_POSE);
    if (in_mode) begin
      if (in_move_code >= MV_BACK) bad = 1'b1;
      if (in_move_code == MV_START && heading_r != DIR_UP) bad = 1'b1;
      if (in_move_code == MV_FORWARD &&
          (in_run_length == 4'd0 || in_run_length > 4'(MAX_RUN))) bad = 1'b1;
    end
  end

  assign run_eff = in_mode ? in_run_length : 4'd1;

  // pose update
  always_comb begin
    heading_nxt = heading_r;
    cell_x_nxt  = cell_x_r;
    cell_y_nxt  = cell_y_r;
    adv         = 8'd0;
    if (in_move_code == MV_RESET_POSE) begin
      heading_nxt = DIR_UP;
      cell_x_nxt  = 8'd0;
      cell_y_nxt  = 8'd0;
    end else if (!bad) begin
      unique case (in_move_code)
        MV_FINISH:     adv = 8'd1;
        MV_FORWARD:    adv = {4'd0, run_eff};
        MV_RIGHT: begin
          adv = 8'd1;
          heading_nxt = heading_r + 2'd1;
        end
        MV_LEFT: begin
          adv = 8'd1;
          heading_nxt = heading_r + 2'd3;
        end
        MV_BACK:       heading_nxt = heading_r + 2'd2;
        MV_BACK_RIGHT: heading_nxt = heading_r + 2'd1;
        MV_BACK_LEFT:  heading_nxt = heading_r + 2'd3;
        default:       adv = 8'd0;
      endcase
      unique case (heading_r)
        DIR_UP:    cell_y_nxt = cell_y_r + adv;
        DIR_RIGHT: cell_x_nxt = cell_x_r + adv;
        DIR_DOWN:  cell_y_nxt = cell_y_r - adv;
        default:   cell_x_nxt = cell_x_r - adv;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heading_r <= DIR_UP;
      cell_x_r  <= 8'd0;
      cell_y_r  <= 8'd0;
    end else if (accept) begin
      heading_r <= heading_nxt;
      cell_x_r  <= cell_x_nxt;
      cell_y_r  <= cell_y_nxt;
    end
  end

  // queue entry carries the pose before this move
  assign q_push           = accept && (in_move_code != MV_RESET_POSE);
  assign q_entry.fast     = in_mode;
  assign q_entry.bad      = bad;
  assign q_entry.code     = in_move_code;
  assign q_entry.run      = run_eff;
  assign q_entry.heading  = heading_r;
  assign q_entry.centre.x = 16'(16'(cell_x_r) * CELL_PITCH + CELL_CENTRE);
  assign q_entry.centre.y = 16'(16'(cell_y_r) * CELL_PITCH + CELL_CENTRE);

endmodule

// ----- src/mzp_fifo.sv -----
module mzp_fifo
  import mzp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t pop_data,
  output logic   full,
  output logic   empty
);

  entry_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0]   count_r;

  assign full     = (count_r == Q_CNT_W'(Q_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue underflow");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not rise");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == Q_CNT_W'(Q_DEPTH)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers out of step");
`endif

endmodule

// ----- src/mzp_back.sv -----
module mzp_back
  import mzp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_empty,
  input  entry_t      q_entry,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_start_x,
  output logic [15:0] out_start_y,
  output logic [15:0] out_ctrl1_x,
  output logic [15:0] out_ctrl1_y,
  output logic [15:0] out_end_x,
  output logic [15:0] out_end_y,
  output logic [15:0] out_ctrl2_x,
  output logic [15:0] out_ctrl2_y,
  output logic [1:0]  out_curve_kind,
  output logic [7:0]  out_speed_begin,
  output logic [7:0]  out_speed_finish,
  output logic        out_bad_move
);

  logic        valid_r;
  point_t      p1_r, d1_r, p2_r, d2_r;
  logic [1:0]  kind_r;
  logic [7:0]  sp1_r, sp2_r;
  logic        bad_r;

  point_t      c, p1, base, mid, d1, p2, d2;
  logic [1:0]  h, fwd, side;
  logic        is_turn, is_back, is_left, is_start;
  logic [15:0] half, quarter, full, s_in, s_out, m1, m2;
  logic [13:0] run_len_mm;
  logic [1:0]  kind;
  logic [7:0]  sp1, sp2;

  assign q_pop = !q_empty && (!valid_r || !out_stall);

  assign half    = 16'(cfg.dist_half);
  assign quarter = 16'(cfg.dist_quarter);
  assign full    = 16'(cfg.dist_full);
  assign s_in    = 16'(cfg.scan_in);
  assign s_out   = 16'(cfg.scan_exit);
  assign run_len_mm = 14'(q_entry.run) * 14'(cfg.dist_full);

  // segment geometry
  always_comb begin
    h        = q_entry.heading;
    is_start = (q_entry.code == MV_START);
    is_back  = (q_entry.code == MV_BACK) || (q_entry.code == MV_BACK_RIGHT) ||
               (q_entry.code == MV_BACK_LEFT);
    is_left  = (q_entry.code == MV_LEFT) || (q_entry.code == MV_BACK_LEFT);
    is_turn  = (q_entry.code == MV_RIGHT) || (q_entry.code == MV_LEFT) ||
               (q_entry.code == MV_BACK_RIGHT) || (q_entry.code == MV_BACK_LEFT);
    fwd      = is_back ? h + 2'd2 : h;
    side     = is_left ? h + 2'd3 : h + 2'd1;
    c        = q_entry.centre;
    p1       = move_pt(c, h, half);
    base     = is_start ? c : p1;
    m1       = is_start ? quarter : half;
    unique case (q_entry.code)
      MV_FORWARD: m2 = 16'(run_len_mm);
      MV_BACK:    m2 = full;
      default:    m2 = half;
    endcase
    mid = move_pt(p1, fwd, half);
    if (is_turn) begin
      d1 = move_pt(p1, fwd, s_in);
      p2 = move_pt(mid, side, half);
      d2 = move_pt(p2, side + 2'd2, s_out);
    end else begin
      d1 = move_pt(base, fwd, m1);
      p2 = move_pt(base, fwd, m2);
      d2 = d1;
    end
  end

  // curve kind and speed codes
  always_comb begin
    kind = q_entry.fast ? KIND_CONST : KIND_SEARCH;
    sp1  = SPEED_NONE;
    sp2  = SPEED_NONE;
    if (q_entry.fast) begin
      if (q_entry.code == MV_FORWARD) begin
        kind = KIND_BRAKE;
        sp1  = SPEED_ONE;
        sp2  = {4'd0, q_entry.run};
      end else if (q_entry.code == MV_RIGHT || q_entry.code == MV_LEFT) begin
        sp1 = SPEED_ONE;
        sp2 = SPEED_ONE;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_entry.bad) begin
        p1_r   <= '0;
        d1_r   <= '0;
        p2_r   <= '0;
        d2_r   <= '0;
        kind_r <= '0;
        sp1_r  <= '0;
        sp2_r  <= '0;
        bad_r  <= 1'b1;
      end else begin
        p1_r   <= is_start ? c : p1;
        d1_r   <= d1;
        p2_r   <= p2;
        d2_r   <= d2;
        kind_r <= kind;
        sp1_r  <= sp1;
        sp2_r  <= sp2;
        bad_r  <= 1'b0;
      end
    end
  end

  assign out_valid        = valid_r;
  assign out_start_x      = p1_r.x;
  assign out_start_y      = p1_r.y;
  assign out_ctrl1_x      = d1_r.x;
  assign out_ctrl1_y      = d1_r.y;
  assign out_end_x        = p2_r.x;
  assign out_end_y        = p2_r.y;
  assign out_ctrl2_x      = d2_r.x;
  assign out_ctrl2_y      = d2_r.y;
  assign out_curve_kind   = kind_r;
  assign out_speed_begin  = sp1_r;
  assign out_speed_finish = sp2_r;
  assign out_bad_move     = bad_r;

`ifndef NO_ASSERTIONS
  a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> valid_r) else $error("popped move not presented");
  a_bad_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && bad_r) |-> (kind_r == '0 && sp1_r == '0 && sp2_r == '0))
    else $error("bad move carries payload");
  a_no_pop_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_stall) |-> !q_pop) else $error("pop over a held result");
`endif

endmodule

// ----- src/maze_move_to_bezier_planner.sv -----
// Maze move to Bezier segment planner.
// Input channel (in_valid / in_stall): one move command per transaction with
// mode, move code and run length. A transaction is taken when in_valid is high
// and in_stall is low. A pose reset command updates the pose and produces no
// result; every other command produces exactly one result transaction.
// Result channel (out_valid / out_stall): start, control and end points of one
// cubic segment, curve kind, speed codes and a bad-move flag. A bad move gives
// all-zero fields with out_bad_move set and leaves the pose unchanged.
// Config channel (cfg_valid / cfg_ready): cfg_ready is always high; cfg_index
// selects one of the five distance registers. Write only while idle.
// A taken command is written into the queue; the back end pops it into its
// output register, which drives out_valid, when out_stall is low or no result
// is held. Throughput: one command per cycle while in_stall is low; the next
// pose is computed combinationally, and a two-entry queue decouples the ends.
// While out_stall holds a result, two more commands fill the queue and then
// in_stall rises. Reset (rst_n low, synchronous) clears the pose to cell 0,0
// heading up, empties the queue and reloads the distance registers.
module maze_move_to_bezier_planner
  import mzp_pkg::*;
#(
  parameter int MAX_RUN = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [3:0]  in_move_code,
  input  logic [3:0]  in_run_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_start_x,
  output logic [15:0] out_start_y,
  output logic [15:0] out_ctrl1_x,
  output logic [15:0] out_ctrl1_y,
  output logic [15:0] out_end_x,
  output logic [15:0] out_end_y,
  output logic [15:0] out_ctrl2_x,
  output logic [15:0] out_ctrl2_y,
  output logic [1:0]  out_curve_kind,
  output logic [7:0]  out_speed_begin,
  output logic [7:0]  out_speed_finish,
  output logic        out_bad_move,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  cfg_t   cfg_r;
  logic   q_push, q_pop, q_full, q_empty;
  entry_t push_entry, pop_entry;

  // distance registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dist_full    <= 10'd180;
      cfg_r.dist_half    <= 10'd90;
      cfg_r.dist_quarter <= 10'd45;
      cfg_r.scan_in      <= 10'd60;
      cfg_r.scan_exit    <= 10'd60;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DIST_FULL:    cfg_r.dist_full    <= cfg_data;
        CFG_DIST_HALF:    cfg_r.dist_half    <= cfg_data;
        CFG_DIST_QUARTER: cfg_r.dist_quarter <= cfg_data;
        CFG_SCAN_IN:      cfg_r.scan_in      <= cfg_data;
        CFG_SCAN_EXIT:    cfg_r.scan_exit    <= cfg_data;
        default:          cfg_r <= cfg_r;
      endcase
    end
  end

  // front end: classify and track pose
  mzp_front #(
    .MAX_RUN (MAX_RUN)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_move_code  (in_move_code),
    .in_run_length (in_run_length),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (push_entry)
  );

  // queue between front and back
  mzp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_entry),
    .pop       (q_pop),
    .pop_data  (pop_entry),
    .full      (q_full),
    .empty     (q_empty)
  );

  // back end: segment geometry and output register
  mzp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_empty          (q_empty),
    .q_entry          (pop_entry),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_start_x      (out_start_x),
    .out_start_y      (out_start_y),
    .out_ctrl1_x      (out_ctrl1_x),
    .out_ctrl1_y      (out_ctrl1_y),
    .out_end_x        (out_end_x),
    .out_end_y        (out_end_y),
    .out_ctrl2_x      (out_ctrl2_x),
    .out_ctrl2_y      (out_ctrl2_y),
    .out_curve_kind   (out_curve_kind),
    .out_speed_begin  (out_speed_begin),
    .out_speed_finish (out_speed_finish),
    .out_bad_move     (out_bad_move)
  );

endmodule

// ----- tb/maze_move_to_bezier_planner_tb.sv -----
module maze_move_to_bezier_planner_tb
  import mzp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_RUN = 14;

  // move modes
  localparam logic SEARCH = 1'b0;
  localparam logic FAST   = 1'b1;

  // default distance registers after reset
  localparam logic [9:0] DEF_FULL    = 10'd180;
  localparam logic [9:0] DEF_HALF    = 10'd90;
  localparam logic [9:0] DEF_QUARTER = 10'd45;
  localparam logic [9:0] DEF_SCAN    = 10'd60;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
  } xy_t;

  // one planned segment as it should leave the block
  typedef struct packed {
    xy_t        p1;
    xy_t        d1;
    xy_t        p2;
    xy_t        d2;
    logic [1:0] kind;
    logic [7:0] sp_b;
    logic [7:0] sp_f;
    logic       bad;
  } seg_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_mode = 1'b0;
  logic [3:0]  in_move_code = 4'd0;
  logic [3:0]  in_run_length = 4'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_start_x, out_start_y, out_ctrl1_x, out_ctrl1_y;
  logic [15:0] out_end_x, out_end_y, out_ctrl2_x, out_ctrl2_y;
  logic [1:0]  out_curve_kind;
  logic [7:0]  out_speed_begin, out_speed_finish;
  logic        out_bad_move;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [9:0]  cfg_data = 10'd0;

  // pose and distance registers as the planner should hold them
  logic [1:0]  pose_heading = DIR_UP;
  logic [7:0]  pose_cx = 8'd0;
  logic [7:0]  pose_cy = 8'd0;
  logic [9:0]  reg_full = DEF_FULL;
  logic [9:0]  reg_half = DEF_HALF;
  logic [9:0]  reg_quarter = DEF_QUARTER;
  logic [9:0]  reg_scan_in = DEF_SCAN;
  logic [9:0]  reg_scan_out = DEF_SCAN;

  seg_t segments_due[$];
  int   mismatches = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;

  maze_move_to_bezier_planner #(.MAX_RUN(MAX_RUN)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_mode(in_mode),
    .in_move_code(in_move_code),
    .in_run_length(in_run_length),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_start_x(out_start_x),
    .out_start_y(out_start_y),
    .out_ctrl1_x(out_ctrl1_x),
    .out_ctrl1_y(out_ctrl1_y),
    .out_end_x(out_end_x),
    .out_end_y(out_end_y),
    .out_ctrl2_x(out_ctrl2_x),
    .out_ctrl2_y(out_ctrl2_y),
    .out_curve_kind(out_curve_kind),
    .out_speed_begin(out_speed_begin),
    .out_speed_finish(out_speed_finish),
    .out_bad_move(out_bad_move),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // step a point by a distance along a heading, 16-bit wrap
  function automatic xy_t nudge(xy_t p, logic [1:0] dir, logic [15:0] mag);
    xy_t r;
    r = p;
    case (dir)
      DIR_UP:    r.y = p.y + mag;
      DIR_RIGHT: r.x = p.x + mag;
      DIR_DOWN:  r.y = p.y - mag;
      default:   r.x = p.x - mag;
    endcase
    return r;
  endfunction

  // move the cell position n cells along a heading, 8-bit wrap
  task automatic step_cells(input logic [1:0] dir, input logic [3:0] n);
    case (dir)
      DIR_UP:    pose_cy = pose_cy + 8'(n);
      DIR_RIGHT: pose_cx = pose_cx + 8'(n);
      DIR_DOWN:  pose_cy = pose_cy - 8'(n);
      default:   pose_cx = pose_cx - 8'(n);
    endcase
  endtask

  // expected segment for one move, updating the pose
  task automatic plan_segment(input logic fast, input logic [3:0] code,
                              input logic [3:0] run, output bit emits, output seg_t s);
    logic [1:0] h;
    logic [1:0] rh;
    logic [3:0] cells;
    xy_t        c;
    bit         bad;
    h = pose_heading;
    rh = h + 2'd1;
    s = '0;
    emits = 1'b1;
    bad = (code > MV_BACK_LEFT) && (code != MV_RESET_POSE);
    if (fast) begin
      if (code >= MV_BACK && code != MV_RESET_POSE) bad = 1'b1;
      if (code == MV_START && h != DIR_UP) bad = 1'b1;
      if (code == MV_FORWARD && (run == 4'd0 || run > MAX_RUN)) bad = 1'b1;
    end
    if (code == MV_RESET_POSE) begin
      // pose reset gives no segment
      pose_heading = DIR_UP;
      pose_cx = 8'd0;
      pose_cy = 8'd0;
      emits = 1'b0;
    end else if (bad) begin
      s.bad = 1'b1;
    end else begin
      s.kind = fast ? KIND_CONST : KIND_SEARCH;
      s.sp_b = SPEED_NONE;
      s.sp_f = SPEED_NONE;
      c.x = 16'(pose_cx) * CELL_PITCH + CELL_CENTRE;
      c.y = 16'(pose_cy) * CELL_PITCH + CELL_CENTRE;
      s.p1 = nudge(c, h, 16'(reg_half));
      case (code)
        MV_START: begin
          s.p1 = c;
          s.d1 = nudge(c, h, 16'(reg_quarter));
          s.p2 = nudge(c, h, 16'(reg_half));
          s.d2 = s.d1;
        end
        MV_FINISH: begin
          s.d1 = nudge(s.p1, h, 16'(reg_half));
          s.p2 = s.d1;
          s.d2 = s.d1;
          step_cells(h, 4'd1);
        end
        MV_FORWARD: begin
          // search forward is always one cell
          cells = fast ? run : 4'd1;
          s.d1 = nudge(s.p1, h, 16'(reg_half));
          s.p2 = nudge(s.p1, h, 16'(cells) * 16'(reg_full));
          s.d2 = s.d1;
          if (fast) begin
            s.kind = KIND_BRAKE;
            s.sp_b = SPEED_ONE;
            s.sp_f = 8'(cells);
          end
          step_cells(h, cells);
        end
        MV_RIGHT: begin
          s.d1 = nudge(s.p1, h, 16'(reg_scan_in));
          s.p2 = nudge(nudge(s.p1, h, 16'(reg_half)), rh, 16'(reg_half));
          s.d2 = nudge(s.p2, rh + 2'd2, 16'(reg_scan_out));
          if (fast) begin
            s.sp_b = SPEED_ONE;
            s.sp_f = SPEED_ONE;
          end
          step_cells(h, 4'd1);
          pose_heading = h + 2'd1;
        end
        MV_LEFT: begin
          s.d1 = nudge(s.p1, h, 16'(reg_scan_in));
          s.p2 = nudge(nudge(s.p1, h, 16'(reg_half)), rh + 2'd2, 16'(reg_half));
          s.d2 = nudge(s.p2, rh, 16'(reg_scan_out));
          if (fast) begin
            s.sp_b = SPEED_ONE;
            s.sp_f = SPEED_ONE;
          end
          step_cells(h, 4'd1);
          pose_heading = h + 2'd3;
        end
        MV_BACK: begin
          s.d1 = nudge(s.p1, h + 2'd2, 16'(reg_half));
          s.p2 = nudge(s.p1, h + 2'd2, 16'(reg_full));
          s.d2 = s.d1;
          pose_heading = h + 2'd2;
        end
        MV_BACK_RIGHT: begin
          s.d1 = nudge(s.p1, h + 2'd2, 16'(reg_scan_in));
          s.p2 = nudge(nudge(s.p1, h + 2'd2, 16'(reg_half)), rh, 16'(reg_half));
          s.d2 = nudge(s.p2, rh + 2'd2, 16'(reg_scan_out));
          pose_heading = h + 2'd1;
        end
        default: begin
          s.d1 = nudge(s.p1, h + 2'd2, 16'(reg_scan_in));
          s.p2 = nudge(nudge(s.p1, h + 2'd2, 16'(reg_half)), rh + 2'd2, 16'(reg_half));
          s.d2 = nudge(s.p2, rh, 16'(reg_scan_out));
          pose_heading = h + 2'd3;
        end
      endcase
    end
  endtask

  // one move transaction; valid stays high so the next one can follow directly
  task automatic send_move(input logic fast, input logic [3:0] code, input logic [3:0] run);
    seg_t s;
    bit   emits;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= fast;
    in_move_code <= code;
    in_run_length <= run;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    plan_segment(fast, code, run, emits, s);
    if (emits) segments_due.push_back(s);
  endtask

  // stop sending and wait for every segment plus the pipeline tail
  task automatic drain();
    in_valid <= 1'b0;
    while (segments_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_DIST_FULL:    reg_full = val;
      CFG_DIST_HALF:    reg_half = val;
      CFG_DIST_QUARTER: reg_quarter = val;
      CFG_SCAN_IN:      reg_scan_in = val;
      CFG_SCAN_EXIT:    reg_scan_out = val;
      default: ;
    endcase
  endtask

  // rewrite all five distance registers, only while idle
  task automatic load_regs(input logic [9:0] full, input logic [9:0] half,
                           input logic [9:0] quarter, input logic [9:0] sin,
                           input logic [9:0] sout);
    write_reg(CFG_DIST_FULL, full);
    write_reg(CFG_DIST_HALF, half);
    write_reg(CFG_DIST_QUARTER, quarter);
    write_reg(CFG_SCAN_IN, sin);
    write_reg(CFG_SCAN_EXIT, sout);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [9:0] pick_dist();
    case ($urandom_range(3))
      0:       return 10'd0;
      1:       return 10'h3FF;
      default: return 10'($urandom);
    endcase
  endfunction

  // mostly legal moves, some malformed ones
  task automatic pick_move(output logic fast, output logic [3:0] code, output logic [3:0] run);
    int roll;
    fast = 1'($urandom_range(1));
    roll = $urandom_range(99);
    if ($urandom_range(9) == 0) run = $urandom_range(1) ? 4'd15 : 4'd0;
    else run = 4'($urandom_range(MAX_RUN, 1));
    if (roll < 3) code = MV_RESET_POSE;
    else if (roll < 6) code = 4'($urandom_range(15, 9));
    else if (!fast) code = 4'($urandom_range(MV_BACK_LEFT, MV_START));
    else if (roll < 10) code = 4'($urandom_range(MV_BACK_LEFT, MV_BACK));
    else if (roll < 18) code = MV_START;
    else code = 4'($urandom_range(MV_LEFT, MV_FINISH));
  endtask

  task automatic run_phase(input int n_moves, input int send_idle, input int rx_stall);
    logic       fast;
    logic [3:0] code;
    logic [3:0] run;
    int         sent;
    idle_pct = send_idle;
    stall_pct = rx_stall;
    sent = 0;
    while (sent < n_moves) begin
      pick_move(fast, code, run);
      send_move(fast, code, run);
      if (code != MV_RESET_POSE) sent++;
    end
    drain();
  endtask

  // every move in both modes, plus the illegal cases
  task automatic test_directed_moves();
    idle_pct = 0;
    stall_pct = 0;
    send_move(SEARCH, MV_START, 4'd1);
    send_move(SEARCH, MV_FORWARD, 4'd5);
    send_move(SEARCH, MV_RIGHT, 4'd1);
    send_move(SEARCH, MV_LEFT, 4'd1);
    send_move(SEARCH, MV_BACK, 4'd1);
    send_move(SEARCH, MV_BACK_RIGHT, 4'd1);
    send_move(SEARCH, MV_BACK_LEFT, 4'd1);
    send_move(SEARCH, MV_FINISH, 4'd1);
    // heading is down here, so a fast start is illegal
    send_move(FAST, MV_START, 4'd1);
    send_move(FAST, MV_RESET_POSE, 4'd0);
    send_move(FAST, MV_START, 4'd1);
    send_move(FAST, MV_FORWARD, 4'd1);
    send_move(FAST, MV_FORWARD, 4'(MAX_RUN));
    send_move(FAST, MV_FORWARD, 4'd0);
    send_move(FAST, MV_FORWARD, 4'd15);
    send_move(FAST, MV_RIGHT, 4'd3);
    send_move(FAST, MV_LEFT, 4'd3);
    send_move(FAST, MV_FINISH, 4'd2);
    send_move(FAST, MV_BACK, 4'd1);
    send_move(FAST, MV_BACK_RIGHT, 4'd1);
    send_move(FAST, MV_BACK_LEFT, 4'd1);
    send_move(SEARCH, 4'd9, 4'd1);
    send_move(FAST, 4'd15, 4'd15);
    send_move(SEARCH, MV_FORWARD, 4'd0);
    send_move(SEARCH, MV_RESET_POSE, 4'd7);
    drain();
  endtask

  // all-zero and all-ones distances, then back to defaults
  task automatic test_register_extremes();
    load_regs(10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
    run_phase(60, 26, 26);
    load_regs(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);
    run_phase(60, 0, 0);
    load_regs(DEF_FULL, DEF_HALF, DEF_QUARTER, DEF_SCAN, DEF_SCAN);
  endtask

  // long runs that wrap the cell counters and the point coordinates
  task automatic test_cell_wrap();
    load_regs(10'h3FF, pick_dist(), pick_dist(), pick_dist(), pick_dist());
    idle_pct = 0;
    stall_pct = 64;
    send_move(FAST, MV_RESET_POSE, 4'd0);
    send_move(FAST, MV_START, 4'd1);
    repeat (19) send_move(FAST, MV_FORWARD, 4'(MAX_RUN));
    send_move(FAST, MV_LEFT, 4'd1);
    repeat (20) send_move(FAST, MV_FORWARD, 4'(MAX_RUN));
    send_move(SEARCH, MV_BACK, 4'd1);
    send_move(SEARCH, MV_BACK_LEFT, 4'd1);
    send_move(FAST, MV_FINISH, 4'd1);
    drain();
  endtask

  // random move streams under each idling pattern and random distances
  task automatic test_random_moves();
    int ph;
    for (ph = 0; ph < 8; ph++) begin
      load_regs(pick_dist(), pick_dist(), pick_dist(), pick_dist(), pick_dist());
      case (ph % 4)
        0:       run_phase(205, 0, 0);
        1:       run_phase(205, 64, 0);
        2:       run_phase(205, 0, 64);
        default: run_phase(205, 26, 26);
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // compare each segment transaction with the oldest planned one
  always @(posedge clk) begin
    seg_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (segments_due.size() == 0) begin
        $error("segment transaction with none pending");
        mismatches++;
      end else begin
        want = segments_due.pop_front();
        check_field("start_x", want.p1.x, out_start_x);
        check_field("start_y", want.p1.y, out_start_y);
        check_field("ctrl1_x", want.d1.x, out_ctrl1_x);
        check_field("ctrl1_y", want.d1.y, out_ctrl1_y);
        check_field("end_x", want.p2.x, out_end_x);
        check_field("end_y", want.p2.y, out_end_y);
        check_field("ctrl2_x", want.d2.x, out_ctrl2_x);
        check_field("ctrl2_y", want.d2.y, out_ctrl2_y);
        check_field("curve_kind", 16'(want.kind), 16'(out_curve_kind));
        check_field("speed_begin", 16'(want.sp_b), 16'(out_speed_begin));
        check_field("speed_finish", 16'(want.sp_f), 16'(out_speed_finish));
        check_field("bad_move", 16'(want.bad), 16'(out_bad_move));
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_moves();
    test_register_extremes();
    test_cell_wrap();
    test_random_moves();
    if (mismatches == 0) begin
      $display("maze_move_to_bezier_planner_tb OK");
    end else begin
      $display("maze_move_to_bezier_planner_tb NOT OK");
    end
    $finish;
  end

  // hang guard
  initial begin
    #500000;
    $display("maze_move_to_bezier_planner_tb NOT OK");
    $finish;
  end

endmodule

// ----- files.f -----
src/mzp_pkg.sv
src/mzp_front.sv
src/mzp_fifo.sv
src/mzp_back.sv
src/maze_move_to_bezier_planner.sv
tb/maze_move_to_bezier_planner_tb.sv
